/* hw/rtl/mns_pkg.sv */
// shared types, constants and the note frequency table of the melody note sequencer
package mns_pkg;

  localparam int unsigned CLK_W           = 28;
  localparam int unsigned DIV_W           = CLK_W - 1;
  localparam int unsigned FREQ_W          = 13;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned HALF_W          = 16;
  localparam int unsigned ROM_IDX_W       = 6;
  localparam int unsigned NOTE_TABLE_SIZE = 39;
  localparam int unsigned ROM_LEN         = 39;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CNT_W           = $clog2(DIV_W);

  localparam logic [BYTE_W-1:0] END_MARK    = 8'hFF;
  localparam logic [CLK_W-1:0]  CLOCK_RESET = 28'd16000000;

  typedef enum logic [1:0] {
    KIND_NOTE = 2'd0,
    KIND_REST = 2'd1,
    KIND_END  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [FREQ_W-1:0]   freq;
    logic [BYTE_W-1:0]   duration;
  } cmd_t;

  function automatic logic [FREQ_W-1:0] note_freq(input logic [ROM_IDX_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    unique case (idx)
      6'd1:    f = 13'd748;
      6'd2:    f = 13'd807;
      6'd3:    f = 13'd940;
      6'd4:    f = 13'd997;
      6'd5:    f = 13'd1120;
      6'd6:    f = 13'd1257;
      6'd7:    f = 13'd1411;
      6'd11:   f = 13'd1494;
      6'd12:   f = 13'd1651;
      6'd13:   f = 13'd1883;
      6'd14:   f = 13'd1995;
      6'd15:   f = 13'd2239;
      6'd16:   f = 13'd2515;
      6'd17:   f = 13'd2823;
      6'd21:   f = 13'd2988;
      6'd22:   f = 13'd3357;
      6'd23:   f = 13'd3769;
      6'd24:   f = 13'd3996;
      6'd25:   f = 13'd4485;
      6'd26:   f = 13'd5030;
      6'd27:   f = 13'd5646;
      6'd31:   f = 13'd3715;
      6'd32:   f = 13'd4177;
      6'd33:   f = 13'd4645;
      6'd34:   f = 13'd4951;
      6'd35:   f = 13'd5569;
      6'd36:   f = 13'd6197;
      6'd37:   f = 13'd6968;
      6'd38:   f = 13'd7440;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/mns_front.sv */
// front end: pairs note and duration bytes and classifies them into commands
module mns_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mns_pkg::BYTE_W-1:0]    sheet_byte_i,
  input  logic                          full_i,
  output logic                          push_o,
  output mns_pkg::cmd_t                 cmd_o
);

  logic                       expect_q, expect_d;
  logic [mns_pkg::BYTE_W-1:0] held_q, held_d;
  logic                       accept;
  logic [mns_pkg::FREQ_W-1:0] freq;
  logic                       bad;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign freq = mns_pkg::note_freq(held_q[mns_pkg::ROM_IDX_W-1:0]);
  assign bad  = (held_q >= mns_pkg::BYTE_W'(mns_pkg::NOTE_TABLE_SIZE))
             || (held_q >= mns_pkg::BYTE_W'(mns_pkg::ROM_LEN))
             || (freq == '0);

  always_comb begin
    expect_d     = expect_q;
    held_d       = held_q;
    push_o       = 1'b0;
    cmd_o.kind   = mns_pkg::KIND_END;
    cmd_o.freq   = '0;
    cmd_o.duration = '0;
    if (!expect_q) begin
      if (sheet_byte_i == mns_pkg::END_MARK) begin
        push_o = accept;
      end else if (accept) begin
        held_d   = sheet_byte_i;
        expect_d = 1'b1;
      end
    end else begin
      push_o         = accept;
      cmd_o.duration = sheet_byte_i;
      if (held_q == '0) begin
        cmd_o.kind = mns_pkg::KIND_REST;
      end else if (bad) begin
        cmd_o.kind = mns_pkg::KIND_BAD;
      end else begin
        cmd_o.kind = mns_pkg::KIND_NOTE;
        cmd_o.freq = freq;
      end
      if (accept) begin
        expect_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b0;
      held_q   <= '0;
    end else begin
      expect_q <= expect_d;
      held_q   <= held_d;
    end
  end

endmodule

/* hw/rtl/mns_fifo.sv */
// short command queue between front end and divider back end
module mns_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mns_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mns_pkg::cmd_t  cmd_o
);

  mns_pkg::cmd_t                entry_q [mns_pkg::QUEUE_DEPTH];
  logic [mns_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [mns_pkg::QCNT_W-1:0]   count_q;
  logic                         do_push, do_pop;

  assign full_o  = (count_q == mns_pkg::QCNT_W'(mns_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hw/rtl/mns_back.sv */
// back end: bit-serial half-period divider and result register
module mns_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mns_pkg::CLK_W-1:0]     clock_hz_i,
  input  logic                          cmd_valid_i,
  input  mns_pkg::cmd_t                 cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [mns_pkg::HALF_W-1:0]    half_period_o,
  output logic [mns_pkg::BYTE_W-1:0]    duration_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                       state_q;
  logic [mns_pkg::DIV_W-1:0]    quo_q;
  logic [mns_pkg::FREQ_W-1:0]   rem_q;
  logic [mns_pkg::FREQ_W-1:0]   div_q;
  logic [mns_pkg::CNT_W-1:0]    cnt_q;
  mns_pkg::kind_e               kind_q;
  logic [mns_pkg::BYTE_W-1:0]   dur_q;
  logic [mns_pkg::FREQ_W:0]     shifted;
  logic [mns_pkg::FREQ_W:0]     diff;
  logic                         fits;

  assign shifted = {rem_q, quo_q[mns_pkg::DIV_W-1]};
  assign fits    = (shifted >= {1'b0, div_q});
  assign diff    = shifted - {1'b0, div_q};

  assign pop_o         = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o   = (state_q == ST_OUT);
  assign kind_o        = kind_q;
  assign duration_o    = dur_q;
  assign half_period_o = (|quo_q[mns_pkg::DIV_W-1:mns_pkg::HALF_W]) ? '1
                       : quo_q[mns_pkg::HALF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      div_q   <= '0;
      kind_q  <= mns_pkg::KIND_END;
      dur_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            kind_q <= cmd_i.kind;
            dur_q  <= cmd_i.duration;
            rem_q  <= '0;
            div_q  <= cmd_i.freq;
            cnt_q  <= '0;
            if (cmd_i.kind == mns_pkg::KIND_NOTE) begin
              quo_q   <= clock_hz_i[mns_pkg::CLK_W-1:1];
              state_q <= ST_DIV;
            end else begin
              quo_q   <= '0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          quo_q <= {quo_q[mns_pkg::DIV_W-2:0], fits};
          rem_q <= fits ? diff[mns_pkg::FREQ_W-1:0] : shifted[mns_pkg::FREQ_W-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == mns_pkg::CNT_W'(mns_pkg::DIV_W - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/melody_note_sequencer_core.sv */
// top level of the melody note sequencer: config register, front end, queue, back end
// end, rest and bad-note results pass the queue and the result register; notes also pass the divider
// the back end takes a new command only after its last result is taken; notes use the 27-step bit-serial divider
// bytes that produce no result are taken every cycle while the 2-entry queue has room
// reset: asynchronous active low; clock_hz returns to 16000000, note position, queue empty
module melody_note_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mns_pkg::CLK_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mns_pkg::BYTE_W-1:0]    sheet_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [mns_pkg::HALF_W-1:0]    half_period_o,
  output logic [mns_pkg::BYTE_W-1:0]    duration_o
);

  logic [mns_pkg::CLK_W-1:0] clock_hz_q;
  logic                      push, full, pop, q_valid;
  mns_pkg::cmd_t             push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= mns_pkg::CLOCK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      clock_hz_q <= cfg_data_i;
    end
  end

  mns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sheet_byte_i (sheet_byte_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  mns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  mns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clock_hz_i    (clock_hz_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .half_period_o (half_period_o),
    .duration_o    (duration_o)
  );

endmodule

/* hw/rtl/mns_checker.sv */
// port-level checker for the melody note sequencer and its bind
module mns_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    kind_o,
  input logic [mns_pkg::HALF_W-1:0]    half_period_o,
  input logic [mns_pkg::BYTE_W-1:0]    duration_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(kind_o) && $stable(half_period_o) && $stable(duration_o))
    else $error("result payload changed while stalled");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == mns_pkg::KIND_END) |-> (half_period_o == '0) && (duration_o == '0))
    else $error("end of song result carries data");

  a_no_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != mns_pkg::KIND_NOTE) |-> (half_period_o == '0))
    else $error("half period set on a non-note result");

endmodule

bind melody_note_sequencer_core mns_checker u_mns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .half_period_o (half_period_o),
  .duration_o    (duration_o)
);

/* tb/melody_note_sequencer_core_tb.sv */
// testbench for melody_note_sequencer_core: random melody sheets checked against a tone predictor
`timescale 1ns / 100ps

module melody_note_sequencer_core_tb;
  import mns_pkg::*;

  typedef struct {
    kind_e             kind;
    logic [HALF_W-1:0] half;
    logic [BYTE_W-1:0] dur;
  } tone_t;

  localparam int unsigned PITCH_HZ [ROM_LEN] = '{
    0, 748, 807, 940, 997, 1120, 1257, 1411, 0, 0,
    0, 1494, 1651, 1883, 1995, 2239, 2515, 2823, 0, 0,
    0, 2988, 3357, 3769, 3996, 4485, 5030, 5646, 0, 0,
    0, 3715, 4177, 4645, 4951, 5569, 6197, 6968, 7440
  };
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_STALL    = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CLK_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] sheet_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        kind_o;
  logic [HALF_W-1:0] half_period_o;
  logic [BYTE_W-1:0] duration_o;

  logic [BYTE_W-1:0] sheet_q[$];
  tone_t             tone_expect_q[$];
  logic [CLK_W-1:0]  core_hz;
  logic              at_duration;
  logic [BYTE_W-1:0] pending_note;
  bit                steady = 1'b0;
  int unsigned       fail_count = 0;
  int unsigned       tones_heard = 0;
  int unsigned       stall_left = 0;
  int unsigned       next_stall_at = 60;

  melody_note_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sheet_byte_i  (sheet_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .half_period_o (half_period_o),
    .duration_o    (duration_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_tone(kind_e k, logic [HALF_W-1:0] h, logic [BYTE_W-1:0] d);
    tone_t t;
    t.kind = k;
    t.half = h;
    t.dur  = d;
    tone_expect_q.push_back(t);
  endfunction

  function automatic void play_byte(logic [BYTE_W-1:0] b);
    int unsigned hz;
    int unsigned q;
    if (!at_duration) begin
      if (b == END_MARK) begin
        push_tone(KIND_END, '0, '0);
      end else begin
        pending_note = b;
        at_duration  = 1'b1;
      end
      return;
    end
    at_duration = 1'b0;
    if (pending_note == 0) begin
      push_tone(KIND_REST, '0, b);
    end else if (pending_note >= NOTE_TABLE_SIZE || pending_note >= ROM_LEN) begin
      push_tone(KIND_BAD, '0, b);
    end else begin
      hz = PITCH_HZ[pending_note];
      if (hz == 0) begin
        push_tone(KIND_BAD, '0, b);
      end else begin
        q = (core_hz / 2) / hz;
        push_tone(KIND_NOTE, (q > 65535) ? 16'hFFFF : q[HALF_W-1:0], b);
      end
    end
  endfunction

  function automatic void check_tone();
    tone_t t;
    if (tone_expect_q.size() == 0) begin
      $display("%0t: unexpected transaction, expected none actual kind %0d half %0d dur %0d",
               $time, kind_o, half_period_o, duration_o);
      fail_count++;
      return;
    end
    t = tone_expect_q.pop_front();
    if (kind_o != t.kind) begin
      $display("%0t: kind mismatch, expected %0d actual %0d", $time, t.kind, kind_o);
      fail_count++;
    end
    if (half_period_o != t.half) begin
      $display("%0t: half_period mismatch, expected %0d actual %0d", $time, t.half,
               half_period_o);
      fail_count++;
    end
    if (duration_o != t.dur) begin
      $display("%0t: duration mismatch, expected %0d actual %0d", $time, t.dur, duration_o);
      fail_count++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) play_byte(sheet_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (sheet_q.size() > 0 && (steady || $urandom_range(99) >= 19)) begin
          in_valid_i   <= 1'b1;
          sheet_byte_i <= sheet_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_tone();
        tones_heard++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (tones_heard >= next_stall_at) begin
        stall_left    = LONG_STALL;
        next_stall_at = next_stall_at + 640;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  task automatic drain();
    forever begin
      @(posedge clk_i);
      if (sheet_q.size() == 0 && !in_valid_i && tone_expect_q.size() == 0) break;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_clock(logic [CLK_W-1:0] hz);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    core_hz = hz;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pair(logic [BYTE_W-1:0] note, logic [BYTE_W-1:0] dur);
    sheet_q.push_back(note);
    sheet_q.push_back(dur);
  endtask

  task automatic queue_random_song(int unsigned n);
    int unsigned cnt;
    int unsigned r;
    logic [BYTE_W-1:0] slots [9];
    slots = '{8, 9, 10, 18, 19, 20, 28, 29, 30};
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        push_pair(BYTE_W'($urandom_range(ROM_LEN - 1, 1)), BYTE_W'($urandom_range(255)));
        cnt += 2;
      end else if (r < 65) begin
        push_pair(8'd0, BYTE_W'($urandom_range(255)));
        cnt += 2;
      end else if (r < 73) begin
        push_pair(BYTE_W'($urandom_range(254, ROM_LEN)), BYTE_W'($urandom_range(255)));
        cnt += 2;
      end else if (r < 80) begin
        push_pair(slots[$urandom_range(8)], BYTE_W'($urandom_range(255)));
        cnt += 2;
      end else if (r < 90) begin
        sheet_q.push_back(END_MARK);
        cnt += 1;
      end else begin
        sheet_q.push_back(BYTE_W'($urandom_range(255)));
        cnt += 1;
      end
    end
  endtask

  initial begin
    logic [CLK_W-1:0] hz_list [6];
    core_hz      = CLOCK_RESET;
    at_duration  = 1'b0;
    pending_note = '0;
    hz_list = '{28'd200000000, 28'd1, 28'd0, 28'hFFFFFFF,
                CLK_W'($urandom_range(200000000, 1)), CLOCK_RESET};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    sheet_q.push_back(END_MARK);
    sheet_q.push_back(END_MARK);
    push_pair(8'd0, 8'd0);
    push_pair(8'd0, 8'hFF);
    push_pair(8'd1, 8'd1);
    push_pair(8'd38, 8'd100);
    push_pair(8'd8, 8'd7);
    push_pair(8'd39, 8'd55);
    push_pair(8'd254, 8'hAA);
    push_pair(8'd21, 8'h55);
    push_pair(8'd30, 8'd3);
    push_pair(8'd128, 8'hFF);
    sheet_q.push_back(END_MARK);

    foreach (hz_list[i]) begin
      drain();
      write_clock(hz_list[i]);
      steady = (i == 5);
      queue_random_song(300);
    end
    drain();

    if (tone_expect_q.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time, tone_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule
